/* hw/rtl/slwe_pkg.sv */
// ----------------------------------------------------------------------------
// slwe_pkg
// Shared types and codes of the string load word executor.
// ----------------------------------------------------------------------------
package slwe_pkg;

	localparam int unsigned NumRegs = 32;
	localparam int unsigned RegAddrW = $clog2(NumRegs);
	localparam logic [31:0] ReturnWord = 32'h4E80_0020;
	localparam logic [5:0] PrimLswi = 6'd31;
	localparam logic [9:0] ExtLswi = 10'd597;
	localparam logic [5:0] MaxStringBytes = 6'd32;
	localparam logic [31:0] BudgetReset = 32'd1024;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_FETCH = 3'd1,
		OP_BYTE  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_FETCH = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_EXIT  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RSN_DONE   = 3'd0,
		RSN_UNSUP  = 3'd1,
		RSN_FAULT  = 3'd2,
		RSN_BUDGET = 3'd3,
		RSN_ENTRY  = 3'd4
	} reason_t;

	typedef enum logic [2:0] {
		CFG_ENTRY  = 3'd0,
		CFG_END    = 3'd1,
		CFG_BUDGET = 3'd2,
		CFG_VALID  = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]          op;
		logic [31:0]         instruction_word;
		logic                access_ok;
		logic [7:0]          data_byte;
		logic [4:0]          reg_index;
		logic [63:0]         write_value;
		logic [RegAddrW-1:0] rf_addr;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [5:0]  req_bytes;
		logic [2:0]  stop_code;
		logic [31:0] run_pc;
		logic [31:0] last_instruction;
		logic [31:0] executed_count;
		logic [63:0] read_value;
	} result_t;

endpackage

/* hw/rtl/slwe_front.sv */
// ----------------------------------------------------------------------------
// slwe_front
// Input queue: takes items, derives the register file read address.
// ----------------------------------------------------------------------------
module slwe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          op,
	input  logic [31:0]         instruction_word,
	input  logic                access_ok,
	input  logic [7:0]          data_byte,
	input  logic [4:0]          reg_index,
	input  logic [63:0]         write_value,
	output logic                q_valid,
	output slwe_pkg::item_t     q_item,
	input  logic                q_take
);
	import slwe_pkg::*;

	item_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	item_t       new_item;
	logic        do_push;

	always_comb begin
		new_item.op = op;
		new_item.instruction_word = instruction_word;
		new_item.access_ok = access_ok;
		new_item.data_byte = data_byte;
		new_item.reg_index = reg_index;
		new_item.write_value = write_value;
		// register reads: op read uses reg_index, fetch uses the RA field
		if (op == OP_READ) begin
			new_item.rf_addr = reg_index;
		end else begin
			new_item.rf_addr = instruction_word[20:16];
		end
	end

	assign full = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (q_take) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, q_take};
		end
	end

endmodule

/* hw/rtl/slwe_resq.sv */
// ----------------------------------------------------------------------------
// slwe_resq
// Two-entry result queue toward the consumer.
// ----------------------------------------------------------------------------
module slwe_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  slwe_pkg::result_t wr_res,
	output logic              rq_full,
	output logic              empty,
	input  logic              pop,
	output slwe_pkg::result_t rd_res
);
	import slwe_pkg::*;

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign rq_full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_pop = pop && !empty;
	assign rd_res = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, do_pop};
		end
	end

endmodule

/* hw/rtl/slwe_back.sv */
// ----------------------------------------------------------------------------
// slwe_back
// Execution part: register file, sequencer state and result forming.
// ----------------------------------------------------------------------------
module slwe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              q_valid,
	input  slwe_pkg::item_t   q_item,
	output logic              q_take,
	input  logic              rq_full,
	output logic              res_push,
	output slwe_pkg::result_t res
);
	import slwe_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FETCH  = 3'b010,
		PH_STRING = 3'b100
	} phase_t;

	logic [31:0] entry_q, end_q, budget_q;
	logic        evalid_q;

	logic [63:0]         mem_q [NumRegs];
	logic [NumRegs-1:0]  rvalid_q;

	logic        valid_s1;
	item_t       item_s1;
	logic [63:0] rdata_s1;

	phase_t      phase_q, phase_d;
	logic [31:0] pc_q, pc_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] cur_q, cur_d;
	logic [4:0]  tgt_q, tgt_d;
	logic [5:0]  len_q, len_d;
	logic [4:0]  bpos_q, bpos_d;
	logic [31:0] acc_q, acc_d;

	logic          fire;
	logic          emit;
	result_t       r;
	logic          we;
	logic [4:0]    waddr;
	logic [63:0]   wdata;
	logic [31:0]   w;
	logic [31:0]   acc_n;
	logic [1:0]    k;
	logic          last;
	logic [31:0]   pc_try;
	logic          try_go;
	logic [31:0]   pc_adv;
	logic [4:0]    nb;

	assign fire = valid_s1 && !rq_full;
	assign q_take = q_valid && (!valid_s1 || fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			end_q <= '0;
			budget_q <= BudgetReset;
			evalid_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTRY:  entry_q <= cfg_data;
				CFG_END:    end_q <= cfg_data;
				CFG_BUDGET: budget_q <= cfg_data;
				CFG_VALID:  evalid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// register file with registered read and write forwarding
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (q_take) begin
			item_s1 <= q_item;
			if (we && waddr == q_item.rf_addr) begin
				rdata_s1 <= wdata;
			end else if (rvalid_q[q_item.rf_addr]) begin
				rdata_s1 <= mem_q[q_item.rf_addr];
			end else begin
				rdata_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
			valid_s1 <= 1'b0;
			phase_q <= PH_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
			cur_q <= '0;
			tgt_q <= '0;
			len_q <= '0;
			bpos_q <= '0;
			acc_q <= '0;
		end else begin
			if (we) rvalid_q[waddr] <= 1'b1;
			if (q_take) valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (fire) begin
				phase_q <= phase_d;
				pc_q <= pc_d;
				cnt_q <= cnt_d;
				cur_q <= cur_d;
				tgt_q <= tgt_d;
				len_q <= len_d;
				bpos_q <= bpos_d;
				acc_q <= acc_d;
			end
		end
	end

	always_comb begin
		w = item_s1.instruction_word;
		k = bpos_q[1:0];
		last = ({1'b0, bpos_q} + 6'd1) >= len_q;
		acc_n = {acc_q[23:0], item_s1.data_byte};
		pc_adv = pc_q + 32'd4;
		nb = w[15:11];
		phase_d = phase_q;
		pc_d = pc_q;
		cnt_d = cnt_q;
		cur_d = cur_q;
		tgt_d = tgt_q;
		len_d = len_q;
		bpos_d = bpos_q;
		acc_d = acc_q;
		emit = 1'b0;
		we = 1'b0;
		waddr = item_s1.reg_index;
		wdata = item_s1.write_value;
		pc_try = pc_q;
		try_go = 1'b0;
		r = '0;
		unique case (item_s1.op)
			OP_START: begin
				cnt_d = '0;
				cur_d = '0;
				pc_d = entry_q;
				emit = 1'b1;
				r.kind = KIND_EXIT;
				r.run_pc = entry_q;
				if (budget_q == '0) begin
					r.stop_code = RSN_BUDGET;
					phase_d = PH_IDLE;
				end else if (!evalid_q) begin
					r.stop_code = RSN_ENTRY;
					phase_d = PH_IDLE;
				end else begin
					pc_try = entry_q;
					try_go = 1'b1;
				end
			end
			OP_FETCH: begin
				if (phase_q == PH_FETCH) begin
					emit = 1'b1;
					r.kind = KIND_EXIT;
					r.run_pc = pc_q;
					r.last_instruction = cur_q;
					r.executed_count = cnt_q;
					phase_d = PH_IDLE;
					if (!item_s1.access_ok) begin
						r.stop_code = RSN_FAULT;
					end else begin
						cur_d = w;
						cnt_d = cnt_q + 32'd1;
						r.last_instruction = w;
						r.executed_count = cnt_d;
						if (w == ReturnWord) begin
							r.stop_code = RSN_DONE;
						end else if (w[31:26] != PrimLswi || w[10:1] != ExtLswi) begin
							r.stop_code = RSN_UNSUP;
						end else begin
							tgt_d = w[25:21];
							len_d = (nb == '0) ? MaxStringBytes : {1'b0, nb};
							bpos_d = '0;
							acc_d = '0;
							phase_d = PH_STRING;
							r.kind = KIND_DATA;
							r.address = (w[20:16] == '0) ? 32'd0 : rdata_s1[31:0];
							r.req_bytes = len_d;
						end
					end
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_STRING) begin
					if (bpos_q == '0 && !item_s1.access_ok) begin
						emit = 1'b1;
						r.kind = KIND_EXIT;
						r.stop_code = RSN_FAULT;
						r.run_pc = pc_q;
						r.last_instruction = cur_q;
						r.executed_count = cnt_q;
						phase_d = PH_IDLE;
					end else begin
						acc_d = acc_n;
						if (k == 2'd3 || last) begin
							we = 1'b1;
							waddr = tgt_q + {2'b00, bpos_q[4:2]};
							wdata = {32'd0, acc_n << {~k, 3'b000}};
							acc_d = '0;
						end
						if (last) begin
							pc_d = pc_adv;
							if (cnt_q >= budget_q) begin
								emit = 1'b1;
								r.kind = KIND_EXIT;
								r.stop_code = RSN_BUDGET;
								r.run_pc = pc_adv;
								r.last_instruction = cur_q;
								r.executed_count = cnt_q;
								phase_d = PH_IDLE;
							end else begin
								pc_try = pc_adv;
								try_go = 1'b1;
							end
						end else begin
							bpos_d = bpos_q + 5'd1;
						end
					end
				end
			end
			OP_WRITE: begin
				we = 1'b1;
			end
			OP_READ: begin
				emit = 1'b1;
				r.kind = KIND_READ;
				r.read_value = rdata_s1;
			end
			default: ;
		endcase
		if (try_go) begin
			emit = 1'b1;
			r.run_pc = pc_try;
			r.last_instruction = cur_d;
			r.executed_count = cnt_d;
			if (pc_try < entry_q || pc_try > end_q) begin
				r.kind = KIND_EXIT;
				r.stop_code = RSN_FAULT;
				phase_d = PH_IDLE;
			end else begin
				r.kind = KIND_FETCH;
				r.stop_code = RSN_DONE;
				r.address = pc_try;
				phase_d = PH_FETCH;
			end
		end
		we = we && fire;
	end

	assign res_push = fire && emit;
	assign res = r;

`ifndef SYNTH
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q)) else $error("phase not one-hot");
	a_string_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STRING |-> len_q != 6'd0) else $error("string without length");
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> valid_s1) else $error("taken item lost");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !rq_full) else $error("result pushed into full queue");
`endif

endmodule

/* hw/rtl/string_load_word_executor_core.sv */
// ----------------------------------------------------------------------------
// string_load_word_executor_core
// Sequencer for load-string-word-immediate guest functions.
//
//  channel   handshake          payload
//  input     push / full        op instruction_word access_ok data_byte
//                               reg_index write_value
//  result    empty / pop        kind address req_bytes stop_code run_pc
//                               last_instruction executed_count read_value
//  config    cfg_we             cfg_index cfg_data
//
// one item per cycle while the result queue has room; an accepted item passes
// the input queue and register file read, then executes into the result queue
// reset clears the control state; the register file reads zero until written
// full rises when the two-entry input queue fills; a full result queue stalls
// execution while the input queue still takes items
// ----------------------------------------------------------------------------
module string_load_word_executor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [31:0] instruction_word,
	input  logic        access_ok,
	input  logic [7:0]  data_byte,
	input  logic [4:0]  reg_index,
	input  logic [63:0] write_value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] address,
	output logic [5:0]  req_bytes,
	output logic [2:0]  stop_code,
	output logic [31:0] run_pc,
	output logic [31:0] last_instruction,
	output logic [31:0] executed_count,
	output logic [63:0] read_value
);
	import slwe_pkg::*;

	logic    q_valid;
	item_t   q_item;
	logic    q_take;
	logic    rq_full;
	logic    res_push;
	result_t res;
	result_t out_res;

	slwe_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.instruction_word(instruction_word), .access_ok(access_ok),
		.data_byte(data_byte), .reg_index(reg_index), .write_value(write_value),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	slwe_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
		.rq_full(rq_full), .res_push(res_push), .res(res)
	);

	slwe_resq u_resq (
		.clk(clk), .arst_n(arst_n), .wr_en(res_push), .wr_res(res),
		.rq_full(rq_full), .empty(empty), .pop(pop), .rd_res(out_res)
	);

	assign kind = out_res.kind;
	assign address = out_res.address;
	assign req_bytes = out_res.req_bytes;
	assign stop_code = out_res.stop_code;
	assign run_pc = out_res.run_pc;
	assign last_instruction = out_res.last_instruction;
	assign executed_count = out_res.executed_count;
	assign read_value = out_res.read_value;

endmodule

/* tb/tb_string_load_word_executor_core.sv */
// ----------------------------------------------------------------------------
// tb_string_load_word_executor_core
// Self-checking testbench for the string load word executor. A local
// predictor tracks the register file, pc, counters and run phase. It predicts
// every request, exit and read transaction in order. Directed cases come
// first, then random guest programs under several entry, end and budget
// settings. Both queue sides idle at random, and one long hold-off on the
// result side fills the block.
// ----------------------------------------------------------------------------
module tb_string_load_word_executor_core;
	import slwe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {PH_IDLE, PH_FETCH, PH_STRING} phase_t;
	localparam logic [2:0] CfgUnused = 3'd7;
	localparam logic [2:0] OpUnknown = 3'd5;
	localparam logic [2:0] OpLast = 3'd7;
	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned TailCycles = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  op = '0;
	logic [31:0] instruction_word = '0;
	logic        access_ok = 1'b0;
	logic [7:0]  data_byte = '0;
	logic [4:0]  reg_index = '0;
	logic [63:0] write_value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [5:0]  req_bytes;
	logic [2:0]  stop_code;
	logic [31:0] run_pc;
	logic [31:0] last_instruction;
	logic [31:0] executed_count;
	logic [63:0] read_value;

	string_load_word_executor_core uut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] p_entry, p_end, p_budget;
	logic        p_valid;
	logic [63:0] p_regs [NumRegs];
	logic [31:0] p_pc, p_count, p_instr, p_acc;
	logic [4:0]  p_target, p_pos;
	logic [5:0]  p_len;
	phase_t      p_phase;

	result_t     pending_results[$];
	int unsigned items_sent, results_seen, exits_seen, errors, cycles;
	int unsigned rx_hold, rx_freeze;
	bit          quiet;

	function automatic result_t blank_result();
		result_t r;
		r = '0;
		return r;
	endfunction

	function automatic result_t stop_run(reason_t rsn, logic [31:0] pc);
		result_t r;
		r = blank_result();
		p_phase = PH_IDLE;
		r.kind = KIND_EXIT;
		r.stop_code = rsn;
		r.run_pc = pc;
		r.last_instruction = p_instr;
		r.executed_count = p_count;
		return r;
	endfunction

	function automatic result_t next_fetch();
		result_t r;
		r = blank_result();
		if (p_pc < p_entry || p_pc > p_end) return stop_run(RSN_FAULT, p_pc);
		p_phase = PH_FETCH;
		r.kind = KIND_FETCH;
		r.address = p_pc;
		r.run_pc = p_pc;
		r.last_instruction = p_instr;
		r.executed_count = p_count;
		return r;
	endfunction

	// returns 1 when the transaction produces a result
	function automatic bit predict_item(input logic [2:0] o, input logic [31:0] w,
			input logic ok, input logic [7:0] b, input logic [4:0] ri,
			input logic [63:0] wv, output result_t r);
		logic [4:0] ra, nb;
		logic [1:0] k;
		bit last;
		r = blank_result();
		case (o)
			OP_START: begin
				p_count = '0;
				p_instr = '0;
				p_pc = p_entry;
				if (p_budget == 0) r = stop_run(RSN_BUDGET, p_entry);
				else if (!p_valid) r = stop_run(RSN_ENTRY, p_entry);
				else r = next_fetch();
				return 1;
			end
			OP_FETCH: begin
				if (p_phase != PH_FETCH) return 0;
				if (!ok) begin
					r = stop_run(RSN_FAULT, p_pc);
					return 1;
				end
				p_instr = w;
				p_count = p_count + 32'd1;
				if (w == ReturnWord) r = stop_run(RSN_DONE, p_pc);
				else if (w[31:26] != PrimLswi || w[10:1] != ExtLswi)
					r = stop_run(RSN_UNSUP, p_pc);
				else begin
					p_target = w[25:21];
					ra = w[20:16];
					nb = w[15:11];
					p_len = (nb == 0) ? MaxStringBytes : {1'b0, nb};
					p_pos = '0;
					p_acc = '0;
					p_phase = PH_STRING;
					r.kind = KIND_DATA;
					r.address = (ra == 0) ? 32'd0 : p_regs[ra][31:0];
					r.req_bytes = p_len;
					r.run_pc = p_pc;
					r.last_instruction = p_instr;
					r.executed_count = p_count;
				end
				return 1;
			end
			OP_BYTE: begin
				if (p_phase != PH_STRING) return 0;
				k = p_pos[1:0];
				last = (int'(p_pos) + 1 >= int'(p_len));
				if (p_pos == 0 && !ok) begin
					r = stop_run(RSN_FAULT, p_pc);
					return 1;
				end
				p_acc = {p_acc[23:0], b};
				if (k == 2'd3 || last) begin
					p_regs[5'(p_target + (p_pos >> 2))] = {32'd0, p_acc << (8 * (3 - k))};
					p_acc = '0;
				end
				if (last) begin
					p_pc = p_pc + 32'd4;
					if (p_count >= p_budget) r = stop_run(RSN_BUDGET, p_pc);
					else r = next_fetch();
					return 1;
				end
				p_pos = p_pos + 5'd1;
				return 0;
			end
			OP_WRITE: begin
				p_regs[ri] = wv;
				return 0;
			end
			OP_READ: begin
				r.kind = KIND_READ;
				r.read_value = p_regs[ri];
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic send_item(input logic [2:0] o, input logic [31:0] w, input logic ok,
			input logic [7:0] b, input logic [4:0] ri, input logic [63:0] wv);
		int unsigned gap;
		result_t r;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		instruction_word <= w;
		access_ok <= ok;
		data_byte <= b;
		reg_index <= ri;
		write_value <= wv;
		do @(posedge clk); while (full);
		items_sent++;
		if (predict_item(o, w, ok, b, ri, wv, r)) pending_results.push_back(r);
	endtask

	task automatic send_noisy(input logic [2:0] o, input logic [31:0] w, input logic ok,
			input logic [7:0] b);
		send_item(o, w, ok, b, 5'($urandom), {$urandom, $urandom});
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ENTRY: p_entry = val;
			CFG_END: p_end = val;
			CFG_BUDGET: p_budget = val;
			CFG_VALID: p_valid = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] ent, input logic [31:0] fin,
			input logic [31:0] bud, input logic vld);
		wait_drained();
		write_reg(CFG_ENTRY, ent);
		write_reg(CFG_END, fin);
		write_reg(CFG_BUDGET, bud);
		write_reg(CFG_VALID, {31'($urandom), vld});
	endtask

	function automatic logic [31:0] lswi(input logic [4:0] rt, input logic [4:0] ra,
			input logic [4:0] nb, input logic rc);
		return {PrimLswi, rt, ra, nb, ExtLswi, rc};
	endfunction

	// start then a well-formed run with random content and some noise
	task automatic run_program(input int unsigned n_instr, input int unsigned fault_pct);
		int unsigned done_instr;
		logic [31:0] w;
		logic [4:0] nb;
		done_instr = 0;
		send_noisy(OP_START, $urandom, 1'($urandom), 8'($urandom));
		while (p_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < 6) begin
				case ($urandom_range(0, 3))
					0: send_noisy(OP_WRITE, $urandom, 1'($urandom), 8'($urandom));
					1: send_noisy(OP_READ, $urandom, 1'($urandom), 8'($urandom));
					2: send_noisy(3'($urandom_range(OpUnknown, OpLast)), $urandom,
						1'($urandom), 8'($urandom));
					default: send_noisy(p_phase == PH_FETCH ? OP_BYTE : OP_FETCH,
						$urandom, 1'($urandom), 8'($urandom));
				endcase
			end else if (p_phase == PH_FETCH) begin
				nb = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 9));
				if (done_instr >= n_instr) w = ReturnWord;
				else if ($urandom_range(0, 99) < 3) w = $urandom;
				else w = lswi(5'($urandom), 5'($urandom), nb, 1'($urandom));
				done_instr++;
				send_noisy(OP_FETCH, w, $urandom_range(0, 99) >= fault_pct, 8'($urandom));
			end else begin
				send_noisy(OP_BYTE, $urandom, $urandom_range(0, 99) >= fault_pct,
					8'($urandom));
			end
		end
	endtask

	// result side: checks each transaction against the oldest expectation
	always @(posedge clk) begin
		result_t e;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
		if (rx_freeze > 0) rx_freeze--;
		if (pop && !empty) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction, kind %0d", kind);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (kind == KIND_EXIT) exits_seen++;
				if (kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, kind); errors++;
				end
				if (address !== e.address) begin
					$error("address exp %h got %h", e.address, address); errors++;
				end
				if (req_bytes !== e.req_bytes) begin
					$error("req_bytes exp %0d got %0d", e.req_bytes, req_bytes); errors++;
				end
				if (stop_code !== e.stop_code) begin
					$error("stop_code exp %0d got %0d", e.stop_code, stop_code); errors++;
				end
				if (run_pc !== e.run_pc) begin
					$error("run_pc exp %h got %h", e.run_pc, run_pc); errors++;
				end
				if (last_instruction !== e.last_instruction) begin
					$error("last_instruction exp %h got %h", e.last_instruction,
						last_instruction); errors++;
				end
				if (executed_count !== e.executed_count) begin
					$error("executed_count exp %0d got %0d", e.executed_count,
						executed_count); errors++;
				end
				if (read_value !== e.read_value) begin
					$error("read_value exp %h got %h", e.read_value, read_value); errors++;
				end
			end
			rx_hold = quiet ? 0 : $urandom_range(0, 11);
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		pop <= (rx_hold == 0) && (rx_freeze == 0);
	end

	task automatic test_directed();
		int i;
		send_noisy(OP_READ, '0, 1'b1, '0);
		send_item(OP_READ, '0, 1'b0, '0, 5'd31, '0);
		send_noisy(OP_START, '0, 1'b1, '0);
		send_noisy(OP_BYTE, '1, 1'b1, 8'hFF);
		send_noisy(OpUnknown, '1, 1'b1, 8'hFF);
		send_noisy(OpLast, '1, 1'b1, 8'hFF);
		configure(32'h100, 32'h10C, '0, 1'b1);
		write_reg(CfgUnused, '1);
		send_noisy(OP_START, '0, 1'b1, '0);
		configure(32'h100, 32'h10C, BudgetReset, 1'b1);
		send_item(OP_WRITE, '0, 1'b1, '0, 5'd31, '1);
		send_item(OP_READ, '0, 1'b1, '0, 5'd31, '0);
		send_noisy(OP_START, '0, 1'b1, '0);
		send_noisy(OP_FETCH, lswi(5'd30, 5'd31, 5'd0, 1'b1), 1'b1, '0);
		for (i = 0; i < 32; i++)
			send_noisy(OP_BYTE, '0, 1'b1, (i % 2) ? 8'hFF : 8'h00);
		send_noisy(OP_FETCH, lswi(5'd31, 5'd0, 5'd5, 1'b0), 1'b1, '0);
		for (i = 0; i < 5; i++) send_noisy(OP_BYTE, '0, 1'b1, 8'hA5);
		send_noisy(OP_FETCH, 32'h7C00_0000, 1'b1, '0);
		send_item(OP_READ, '0, 1'b1, '0, 5'd0, '0);
		send_item(OP_READ, '0, 1'b1, '0, 5'd31, '0);
		send_noisy(OP_START, '0, 1'b1, '0);
		send_noisy(OP_FETCH, ReturnWord, 1'b0, '0);
		send_noisy(OP_START, '0, 1'b1, '0);
		send_noisy(OP_FETCH, lswi(5'd1, 5'd0, 5'd2, 1'b0), 1'b1, '0);
		send_noisy(OP_START, '0, 1'b1, '0);
		send_noisy(OP_FETCH, ReturnWord, 1'b1, '0);
	endtask

	task automatic test_settings();
		int unsigned pick;
		while (items_sent < 880) begin
			pick = $urandom_range(0, 6);
			case (pick)
				0: configure(32'h1000, 32'h1000 + 4 * $urandom_range(0, 30), BudgetReset, 1'b1);
				1: configure('0, '1, '1, 1'b1);
				2: configure(32'hFFFF_FFF8, '1, $urandom_range(1, 8), 1'b1);
				3: configure(32'h2000, 32'h2100, $urandom_range(1, 3), 1'b1);
				4: configure(32'h3000, 32'h2FFC, 32'd10, 1'b1);
				5: configure($urandom, '1, $urandom_range(0, 2) == 0 ? '0 : $urandom, 1'($urandom));
				default: ;
			endcase
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 3))
				run_program($urandom_range(0, 8), $urandom_range(0, 3) == 0 ? 8 : 0);
			quiet = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		configure('0, '1, '1, 1'b1);
		rx_freeze = 400;
		quiet = 1'b1;
		run_program(6, 0);
		quiet = 1'b0;
	endtask

	task automatic test_sender_pause();
		run_program(4, 0);
		wait_drained();
		run_program(4, 0);
	endtask

	initial begin
		p_entry = '0;
		p_end = '0;
		p_budget = BudgetReset;
		p_valid = 1'b0;
		foreach (p_regs[i]) p_regs[i] = '0;
		p_pc = '0;
		p_count = '0;
		p_instr = '0;
		p_acc = '0;
		p_target = '0;
		p_pos = '0;
		p_len = '0;
		p_phase = PH_IDLE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_sender_pause();
		test_settings();
		wait_drained();
		$display("%0d transactions sent, %0d results checked, %0d exits", items_sent,
			results_seen, exits_seen);
		$display("covered directed corners, random programs, back pressure and pauses");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
